/* hdl/bpt_pkg.sv */
// Shared types, constants and helpers for the bandwidth pressure tuner.
// No dependencies; imported by bandwidth_pressure_tuner_core.
`timescale 1ns / 1ps
package bpt_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DIV_BW,
        S_EMA1,
        S_EMA2,
        S_EMA_DIV,
        S_PRES,
        S_PRES_DIV,
        S_KNOB,
        S_FIN
    } state_t;

    localparam int CFG_W      = 20;
    localparam int ALPHA_W    = 7;
    localparam int PRES_W     = 17;
    localparam int HOT_W      = 14;
    localparam int RATE_W     = 18;
    localparam int SMIN_W     = 13;
    localparam int SMAX_W     = 16;
    localparam int MASK_W     = 4;
    localparam int KNOB_CALC_W = 20;

    localparam logic [1:0] REG_BW_HIGH = 2'd0;
    localparam logic [1:0] REG_BW_LOW  = 2'd1;
    localparam logic [1:0] REG_ALPHA   = 2'd2;

    localparam logic [CFG_W-1:0]   BW_HIGH_RST = 20'd60000;
    localparam logic [CFG_W-1:0]   BW_LOW_RST  = 20'd30000;
    localparam logic [ALPHA_W-1:0] ALPHA_RST   = 7'd40;

    localparam logic [HOT_W-1:0]  HOT_DEF  = 14'd1000;
    localparam logic [RATE_W-1:0] RATE_DEF = 18'd65536;
    localparam logic [SMIN_W-1:0] SMIN_DEF = 13'd1000;
    localparam logic [SMAX_W-1:0] SMAX_DEF = 16'd60000;

    localparam logic signed [PRES_W-1:0] Q15_ONE = 17'sd32768;

    typedef logic signed [KNOB_CALC_W-1:0] knob_t;

    // Slope of each knob, chosen by the sign of the pressure
    function automatic logic [16:0] knob_k(input logic [1:0] idx, input logic neg);
        logic [16:0] k;
        k = 17'd0;
        case (idx)
            2'd0: k = neg ? 17'd900   : 17'd9000;
            2'd1: k = neg ? 17'd65536 : 17'd65280;
            2'd2: k = neg ? 17'd800   : 17'd4000;
            default: k = neg ? 17'd55000 : 17'd0;
        endcase
        return k;
    endfunction

    function automatic knob_t clamp_knob(input knob_t v, input knob_t lo, input knob_t hi);
        knob_t r;
        r = v;
        if (v < lo) r = lo;
        if (v > hi) r = hi;
        return r;
    endfunction

endpackage

/* hdl/bandwidth_pressure_tuner_core.sv */
// Bandwidth pressure tuner: sample in, bandwidth, smoothing, pressure and knobs out.
// Depends on bpt_pkg; one shared bit-serial restoring divider does all divisions.
//
//  channel | signals                                       | direction
//  --------+-----------------------------------------------+----------
//  sample  | in_valid, in_ready, count_total, elapsed_us   | in
//  result  | out_valid, out_ready, bandwidth_mbps .. mask  | out
//  config  | psel, penable, pwrite, paddr, pwdata, prdata  | in/out
//
// A baseline or zero-interval request is taken and gives no result.
// A full request runs the 64-step divider for the bandwidth, again for the moving
// average once it holds a value, and again for a pressure between the thresholds;
// a multiply comes first, and the four knobs are worked out in turn before a
// finishing step. The result sits in an output register, so the next
// request is taken while it waits; finishing stalls only if it is still unclaimed.
// Reset is asynchronous and needs no clearing pass.
`timescale 1ns / 1ps
module bandwidth_pressure_tuner_core #(
    parameter int BYTES_PER_COUNT = 64,
    parameter int BW_WIDTH        = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [63:0]                   count_total,
    input  logic [31:0]                   elapsed_us,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [BW_WIDTH-1:0]           bandwidth_mbps,
    output logic [BW_WIDTH-1:0]           smoothed_mbps,
    output logic signed [bpt_pkg::PRES_W-1:0] pressure,
    output logic [bpt_pkg::HOT_W-1:0]     hot_thresh_ms,
    output logic [bpt_pkg::RATE_W-1:0]    promote_rate_mbps,
    output logic [bpt_pkg::SMIN_W-1:0]    scan_min_ms,
    output logic [bpt_pkg::SMAX_W-1:0]    scan_max_ms,
    output logic [bpt_pkg::MASK_W-1:0]    changed_mask
);
    import bpt_pkg::*;

    localparam int FW = BW_WIDTH + 8;
    localparam int CW = ((FW > CFG_W + 8) ? FW : CFG_W + 8) + 1;
    localparam int DW = CW + 2;
    localparam logic [63:0] BW_MAX = (64'd1 << BW_WIDTH) - 64'd1;
    localparam logic [12:0] BPC = 13'(BYTES_PER_COUNT);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]   bw_high_reg, bw_low_reg;
    logic [ALPHA_W-1:0] alpha_reg;

    logic [63:0]  last_count_reg;
    logic         have_base_reg;
    logic [FW-1:0] smooth_reg;
    logic         smooth_valid_reg;
    logic [HOT_W-1:0]  cur_hot_reg;
    logic [RATE_W-1:0] cur_rate_reg;
    logic [SMIN_W-1:0] cur_smin_reg;
    logic [SMAX_W-1:0] cur_smax_reg;

    logic [63:0] div_num_reg;
    logic [32:0] div_rem_reg;
    logic [31:0] div_den_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] elapsed_reg;
    logic [BW_WIDTH-1:0] bw_reg;
    logic [47:0] acc_reg;
    logic        dneg_reg;
    logic signed [PRES_W-1:0] pres_reg;
    logic [1:0]  idx_reg;
    logic [3:0][16:0] scaled_reg;

    logic out_valid_reg;

    // ---- configuration port ----
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb
    begin
        prdata = 32'd0;
        unique case (paddr[3:2])
            REG_BW_HIGH: prdata = 32'(bw_high_reg);
            REG_BW_LOW:  prdata = 32'(bw_low_reg);
            REG_ALPHA:   prdata = 32'(alpha_reg);
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_high_reg <= BW_HIGH_RST;
            bw_low_reg  <= BW_LOW_RST;
            alpha_reg   <= ALPHA_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_BW_HIGH: bw_high_reg <= pwdata[CFG_W-1:0];
                REG_BW_LOW:  bw_low_reg  <= pwdata[CFG_W-1:0];
                REG_ALPHA:   alpha_reg   <= pwdata[ALPHA_W-1:0];
                default:     ;
            endcase
        end
    end

    // ---- divider step ----
    logic [32:0] rem_sh, rem_new;
    logic        ge;
    logic [63:0] num_new;
    always_comb
    begin
        rem_sh  = {div_rem_reg[31:0], div_num_reg[63]};
        ge      = rem_sh >= {1'b0, div_den_reg};
        rem_new = ge ? rem_sh - {1'b0, div_den_reg} : rem_sh;
        num_new = {div_num_reg[62:0], ge};
    end
    logic div_last;
    assign div_last = (cnt_reg == 6'd63);

    // ---- arithmetic helpers ----
    logic [ALPHA_W-1:0] a_eff;
    always_comb
    begin
        a_eff = alpha_reg;
        if (alpha_reg == '0) a_eff = 7'd1;
        if (alpha_reg > 7'd100) a_eff = 7'd100;
    end

    logic [BW_WIDTH-1:0] bw_sat;
    assign bw_sat = (num_new > BW_MAX) ? BW_WIDTH'(BW_MAX) : num_new[BW_WIDTH-1:0];

    logic [CW-1:0] s_ext, lo_ext, hi_ext;
    logic signed [DW-1:0] d_val;
    logic [DW-1:0] d_mag;
    assign s_ext  = CW'(smooth_reg);
    assign lo_ext = CW'({bw_low_reg, 8'd0});
    assign hi_ext = CW'({bw_high_reg, 8'd0});
    always_comb
    begin
        d_val = $signed(DW'(s_ext) << 1)
              - $signed(DW'({{1'b0, bw_high_reg} + {1'b0, bw_low_reg}, 8'd0}));
        d_mag = d_val[DW-1] ? DW'(-d_val) : DW'(d_val);
    end

    logic [16:0] pmag;
    logic [33:0] kprod;
    assign pmag  = pres_reg[PRES_W-1] ? 17'(-pres_reg) : 17'(pres_reg);
    assign kprod = pmag * knob_k(idx_reg, pres_reg[PRES_W-1]);

    // ---- knob combination ----
    knob_t hot_v, rate_v, smin_v, smax_v;
    knob_t sc0, sc1, sc2, sc3;
    logic pneg;
    always_comb
    begin
        pneg = pres_reg[PRES_W-1];
        sc0 = $signed({3'b0, scaled_reg[0]});
        sc1 = $signed({3'b0, scaled_reg[1]});
        sc2 = $signed({3'b0, scaled_reg[2]});
        sc3 = $signed({3'b0, scaled_reg[3]});
        hot_v  = clamp_knob(20'sd1000 + (pneg ? -sc0 : sc0), 20'sd100, 20'sd10000);
        rate_v = clamp_knob(20'sd65536 - (pneg ? -sc1 : sc1), 20'sd256, 20'sd131072);
        smin_v = clamp_knob(20'sd1000 + (pneg ? -sc2 : sc2), 20'sd200, 20'sd5000);
        smax_v = clamp_knob(pneg ? 20'sd60000 - sc3 : 20'sd60000, 20'sd5000, 20'sd60000);
        if (smax_v < smin_v) smax_v = smin_v;
    end

    // ---- sequencer ----
    logic in_acc, skip;
    assign in_acc = in_valid & in_ready;
    assign skip   = !have_base_reg || (elapsed_us == 32'd0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (in_acc && !skip) state_next = S_MUL;
            S_MUL:      state_next = S_DIV_BW;
            S_DIV_BW:   if (div_last) state_next = smooth_valid_reg ? S_EMA1 : S_PRES;
            S_EMA1:     state_next = S_EMA2;
            S_EMA2:     state_next = S_EMA_DIV;
            S_EMA_DIV:  if (div_last) state_next = S_PRES;
            S_PRES:
            begin
                if (bw_high_reg <= bw_low_reg || s_ext <= lo_ext || s_ext >= hi_ext)
                    state_next = S_KNOB;
                else
                    state_next = S_PRES_DIV;
            end
            S_PRES_DIV: if (div_last) state_next = S_KNOB;
            S_KNOB:     if (idx_reg == 2'd3) state_next = S_FIN;
            S_FIN:      if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_base_reg    <= 1'b0;
            smooth_valid_reg <= 1'b0;
            last_count_reg   <= '0;
            smooth_reg       <= '0;
            cur_hot_reg      <= HOT_DEF;
            cur_rate_reg     <= RATE_DEF;
            cur_smin_reg     <= SMIN_DEF;
            cur_smax_reg     <= SMAX_DEF;
            out_valid_reg    <= 1'b0;
            cnt_reg          <= '0;
            idx_reg          <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_FIN) out_valid_reg <= 1'b0;
            if (in_acc)
            begin
                last_count_reg <= count_total;
                have_base_reg  <= 1'b1;
            end
            if (state_reg == S_DIV_BW || state_reg == S_EMA_DIV || state_reg == S_PRES_DIV)
                cnt_reg <= cnt_reg + 6'd1;
            else
                cnt_reg <= '0;
            if (state_reg == S_DIV_BW && div_last && !smooth_valid_reg)
            begin
                smooth_reg       <= {bw_sat, 8'd0};
                smooth_valid_reg <= 1'b1;
            end
            if (state_reg == S_EMA_DIV && div_last)
                smooth_reg <= num_new[FW-1:0];
            if (state_reg == S_KNOB)
                idx_reg <= idx_reg + 2'd1;
            if (state_reg == S_FIN && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
                cur_hot_reg   <= hot_v[HOT_W-1:0];
                cur_rate_reg  <= rate_v[RATE_W-1:0];
                cur_smin_reg  <= smin_v[SMIN_W-1:0];
                cur_smax_reg  <= smax_v[SMAX_W-1:0];
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                div_num_reg <= count_total - last_count_reg;
                elapsed_reg <= elapsed_us;
            end
            S_MUL:
            begin
                div_num_reg <= 64'(div_num_reg * BPC);
                div_rem_reg <= '0;
                div_den_reg <= elapsed_reg;
            end
            S_DIV_BW, S_EMA_DIV, S_PRES_DIV:
            begin
                div_num_reg <= num_new;
                div_rem_reg <= rem_new;
                if (state_reg == S_DIV_BW && div_last) bw_reg <= bw_sat;
                if (state_reg == S_PRES_DIV && div_last)
                    pres_reg <= dneg_reg ? -$signed(PRES_W'(num_new))
                                         : $signed(PRES_W'(num_new));
            end
            S_EMA1:
                acc_reg <= 48'(a_eff) * 48'({bw_reg, 8'd0});
            S_EMA2:
            begin
                div_num_reg <= 64'(acc_reg + 48'(7'd100 - a_eff) * 48'(smooth_reg));
                div_rem_reg <= '0;
                div_den_reg <= 32'd100;
            end
            S_PRES:
            begin
                dneg_reg    <= d_val[DW-1];
                div_num_reg <= 64'(d_mag) << 15;
                div_rem_reg <= '0;
                div_den_reg <= 32'({bw_high_reg - bw_low_reg, 8'd0});
                if (bw_high_reg <= bw_low_reg) pres_reg <= '0;
                else if (s_ext <= lo_ext)      pres_reg <= -Q15_ONE;
                else if (s_ext >= hi_ext)      pres_reg <= Q15_ONE;
            end
            S_KNOB:
                scaled_reg[idx_reg] <= kprod[31:15];
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    bandwidth_mbps    <= bw_reg;
                    smoothed_mbps     <= smooth_reg[FW-1:8];
                    pressure          <= pres_reg;
                    hot_thresh_ms     <= hot_v[HOT_W-1:0];
                    promote_rate_mbps <= rate_v[RATE_W-1:0];
                    scan_min_ms       <= smin_v[SMIN_W-1:0];
                    scan_max_ms       <= smax_v[SMAX_W-1:0];
                    changed_mask      <= {smax_v[SMAX_W-1:0] != cur_smax_reg,
                                          smin_v[SMIN_W-1:0] != cur_smin_reg,
                                          rate_v[RATE_W-1:0] != cur_rate_reg,
                                          hot_v[HOT_W-1:0]   != cur_hot_reg};
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_BW || state_reg == S_PRES_DIV) |-> div_den_reg != 32'd0)
        else $error("divide by zero");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg) else $error("result dropped");
    a_pres_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_KNOB |-> (pres_reg <= Q15_ONE && pres_reg >= -Q15_ONE))
        else $error("pressure out of range");
`endif

endmodule
